@@ design/ddq_pkg.sv @@
// ddq_pkg: shared types and constants for the deque with remove-max
// request and status codes, cell control and scan types
// no dependencies
`timescale 1ns / 1ps

package ddq_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_READ_FRONT = 3'd3,
    REQ_READ_BACK  = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    C_HOLD,
    C_LOAD,
    C_FROM_LEFT,
    C_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     active;
  } cell_ctl_t;

  // running maximum handed along the chain
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] val;
  } scan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_READ
  } state_t;

endpackage

@@ design/ddq_cell.sv @@
// ddq_cell: one storage cell of the deque chain
// holds one entry and one stage of the running-maximum scan
// depends on ddq_pkg
`timescale 1ns / 1ps

module ddq_cell import ddq_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] push_val,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_val,
  input  scan_t                    scan_in,
  input  logic [IDX_W-1:0]         scan_in_idx,
  output logic signed [DATA_W-1:0] val,
  output scan_t                    scan_out,
  output logic [IDX_W-1:0]         scan_out_idx
);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      C_HOLD:       val <= val;
      C_LOAD:       val <= push_val;
      C_FROM_LEFT:  val <= left_val;
      C_FROM_RIGHT: val <= right_val;
      default:      val <= val;
    endcase
  end

  // strict compare keeps the earlier entry on ties
  always_ff @(posedge clk) begin
    if (ctl.active && (!scan_in.ok || (val > scan_in.val))) begin
      scan_out.ok  <= 1'b1;
      scan_out.val <= val;
      scan_out_idx <= IDX_W'(IDX);
    end else begin
      scan_out     <= scan_in;
      scan_out_idx <= scan_in_idx;
    end
  end

endmodule

@@ design/deque_with_remove_max.sv @@
// deque_with_remove_max: bounded double-ended queue of signed words
// top level: controller and the row of ddq_cell storage cells
// depends on ddq_pkg and ddq_cell
`timescale 1ns / 1ps

// usage
//   a request beat (req_type, value) is taken at a rising edge with start
//   high and busy low. results come back on status, has_data, data, last
//   and count, each valid for the one cycle in which done is high; the
//   receiver cannot stall, so every result must be taken when shown.
// request handling
//   push front, push back, clear, unused codes and any remove or read
//   on an empty queue: the result comes in the next cycle, busy
//   stays low, so one such request per cycle.
//   remove max: the running maximum ripples through the cell row, one
//   cell a cycle, with busy high until the result at the end.
//   readout: the row rotates by one cell each cycle for a full turn,
//   which leaves it as it was; one result per stored entry appears on
//   the cycles that present an entry at the row's end, last on the final.
// reset
//   synchronous rst empties the queue and returns to idle; entry cells
//   are not cleared, only the fill count is.

module deque_with_remove_max import ddq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [REQ_W-1:0]                   req_type,
  input  logic signed [DATA_W-1:0]           value,
  output logic                               done,
  output logic [STAT_W-1:0]                  status,
  output logic                               has_data,
  output logic signed [DATA_W-1:0]           data,
  output logic                               last,
  output logic [$clog2(DEPTH+1)-1:0]         count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  // controller state
  state_t         state, state_next;
  logic [CW-1:0]  occ, occ_next;
  logic [IW-1:0]  cnt, cnt_next;
  logic           rd_back, rd_back_next;

  // result beat, registered
  logic                     done_next;
  status_t                  status_next;
  logic                     has_data_next;
  logic signed [DATA_W-1:0] data_next;
  logic                     last_next;

  // cell row
  cell_ctl_t                ctl      [DEPTH];
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  scan_t                    scan_q   [DEPTH];
  logic [IW-1:0]            scan_idx [DEPTH];

  logic [CW-1:0] skip;

  assign busy = (state != S_IDLE);
  // back-first readout idles this many rotations before the back entry shows
  assign skip = CW'(DEPTH) - occ;

  // ends of the row wrap around so that a full rotation restores it
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ddq_cell #(
      .IDX_W (IW),
      .IDX   (g)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl[g]),
      .push_val     (value),
      .left_val     (cell_val[(g == 0) ? DEPTH-1 : g-1]),
      .right_val    (cell_val[(g == DEPTH-1) ? 0 : g+1]),
      .scan_in      ((g == 0) ? scan_t'('0) : scan_q[(g == 0) ? 0 : g-1]),
      .scan_in_idx  ((g == 0) ? IW'(0) : scan_idx[(g == 0) ? 0 : g-1]),
      .val          (cell_val[g]),
      .scan_out     (scan_q[g]),
      .scan_out_idx (scan_idx[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      cnt     <= '0;
      rd_back <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      cnt     <= cnt_next;
      rd_back <= rd_back_next;
      done    <= done_next;
    end
  end

  // result payload, meaningful only with done
  always_ff @(posedge clk) begin
    status   <= status_next;
    has_data <= has_data_next;
    data     <= data_next;
    last     <= last_next;
    count    <= occ_next;
  end

  always_comb begin
    state_next    = state;
    occ_next      = occ;
    cnt_next      = cnt;
    rd_back_next  = rd_back;
    done_next     = 1'b0;
    status_next   = ST_OK;
    has_data_next = 1'b0;
    data_next     = '0;
    last_next     = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].op     = C_HOLD;
      ctl[i].active = (occ > CW'(i));
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_PUSH_FRONT: begin
              done_next = 1'b1;
              if (occ == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  ctl[i].op = (i == 0) ? C_LOAD : C_FROM_LEFT;
                end
                occ_next = occ + CW'(1);
              end
            end
            REQ_PUSH_BACK: begin
              done_next = 1'b1;
              if (occ == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (CW'(i) == occ) ctl[i].op = C_LOAD;
                end
                occ_next = occ + CW'(1);
              end
            end
            REQ_REMOVE: begin
              if (occ == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next = S_SCAN;
                cnt_next   = IW'(DEPTH-1);
              end
            end
            REQ_READ_FRONT, REQ_READ_BACK: begin
              if (occ == '0) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next   = S_READ;
                cnt_next     = '0;
                rd_back_next = (req_type == REQ_READ_BACK);
              end
            end
            REQ_CLEAR: begin
              done_next = 1'b1;
              occ_next  = '0;
            end
            default: begin
              // unused codes: plain ok beat, nothing changes
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // wait for the maximum to reach the end of the row
        if (cnt == '0) begin
          state_next = S_REMOVE;
        end else begin
          cnt_next = cnt - IW'(1);
        end
      end

      S_REMOVE: begin
        // close the gap left by the winning entry
        for (int i = 0; i < DEPTH; i++) begin
          if ((IW'(i) >= scan_idx[DEPTH-1]) && (CW'(i + 1) < occ)) begin
            ctl[i].op = C_FROM_RIGHT;
          end
        end
        occ_next   = occ - CW'(1);
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_READ: begin
        for (int i = 0; i < DEPTH; i++) begin
          ctl[i].op = rd_back ? C_FROM_LEFT : C_FROM_RIGHT;
        end
        if (!rd_back) begin
          // front entry sits in cell zero, rotate left
          if (CW'(cnt) < occ) begin
            done_next     = 1'b1;
            has_data_next = 1'b1;
            data_next     = cell_val[0];
            last_next     = ((CW'(cnt) + CW'(1)) == occ);
          end
        end else begin
          // back entry reaches the last cell after the idle rotations
          if (CW'(cnt) >= skip) begin
            done_next     = 1'b1;
            has_data_next = 1'b1;
            data_next     = cell_val[DEPTH-1];
            last_next     = (cnt == IW'(DEPTH-1));
          end
        end
        if (cnt == IW'(DEPTH-1)) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // removal must find a winner in a non-empty queue
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE) |-> scan_q[DEPTH-1].ok)
    else $error("remove max found no entry");

  // data beats only carry ok status
  assert property (@(posedge clk) disable iff (rst)
    (done && has_data) |-> (status == ST_OK))
    else $error("data beat with bad status");

  // a readout never runs on an empty queue
  assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (occ != '0))
    else $error("readout of empty queue");

  // fill count never goes past the row length
  assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CW'(DEPTH)))
    else $error("count beyond depth");

  // a remove on a non-empty queue goes into the scan
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_REMOVE) && (occ != '0)) |=>
      (state == S_SCAN))
    else $error("remove did not start scan");

endmodule

@@ bench/deque_with_remove_max_test.sv @@
// deque_with_remove_max_test: self-checking bench for the deque with remove-max
// a shadow deque predicts every result beat; depends on ddq_pkg and the dut
`timescale 1ns / 1ps

module deque_with_remove_max_test import ddq_pkg::*;;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ITEMS       = 460;
  localparam int CALM_ITEMS  = 60;       // final stretch with no sender gaps
  localparam int CYCLE_LIMIT = 200000;   // watchdog budget, many times over the worst case

  // request codes the block does not define, must be ignored
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  // random segment shapes
  typedef enum int {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIXED
  } segment_t;

  // one result beat as the block should show it
  typedef struct {
    logic [STAT_W-1:0]        status;
    logic                     has_data;
    logic signed [DATA_W-1:0] data;
    logic                     last;
    logic [CNT_W-1:0]         count;
  } outcome_t;

  // shadow deque plus the result beats it still owes
  class dq_shadow;
    logic signed [DATA_W-1:0] held[$];
    outcome_t                 owed[$];
    int unsigned              errors;

    function new();
      errors = 0;
    endfunction

    function void owe(logic [STAT_W-1:0] st, logic hd, logic signed [DATA_W-1:0] d,
                      logic lst);
      outcome_t o;
      o.status   = st;
      o.has_data = hd;
      o.data     = d;
      o.last     = lst;
      o.count    = CNT_W'(held.size());
      owed.push_back(o);
    endfunction

    // called once per accepted request beat
    function void note_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] word);
      int n;
      int best;
      n = held.size();
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (n >= DEPTH) begin
            owe(ST_FULL, 1'b0, '0, 1'b1);
          end else begin
            if (req == REQ_PUSH_FRONT) held.push_front(word);
            else held.push_back(word);
            owe(ST_OK, 1'b0, '0, 1'b1);
          end
        end
        REQ_REMOVE: begin
          if (n == 0) begin
            owe(ST_EMPTY, 1'b0, '0, 1'b1);
          end else begin
            // strict compare keeps the frontmost of equal maxima
            best = 0;
            for (int i = 1; i < n; i++)
              if (held[i] > held[best]) best = i;
            held.delete(best);
            owe(ST_OK, 1'b0, '0, 1'b1);
          end
        end
        REQ_READ_FRONT, REQ_READ_BACK: begin
          if (n == 0) begin
            owe(ST_EMPTY, 1'b0, '0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              owe(ST_OK, 1'b1, held[(req == REQ_READ_FRONT) ? i : n - 1 - i], i == n - 1);
          end
        end
        REQ_CLEAR: begin
          held.delete();
          owe(ST_OK, 1'b0, '0, 1'b1);
        end
        default: begin
          owe(ST_OK, 1'b0, '0, 1'b1);
        end
      endcase
    endfunction

    // called for every result beat the block strobes
    function void check_result(logic [STAT_W-1:0] st, logic hd, logic signed [DATA_W-1:0] d,
                               logic lst, logic [CNT_W-1:0] cnt);
      outcome_t o;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: status %0d data %0d", st, d);
        errors++;
        return;
      end
      o = owed.pop_front();
      if (st !== o.status) begin
        $error("status mismatch: expected %0d, actual %0d", o.status, st);
        errors++;
      end
      if (hd !== o.has_data) begin
        $error("has_data mismatch: expected %0d, actual %0d", o.has_data, hd);
        errors++;
      end
      if (d !== o.data) begin
        $error("data mismatch: expected %0d, actual %0d", o.data, d);
        errors++;
      end
      if (lst !== o.last) begin
        $error("last mismatch: expected %0d, actual %0d", o.last, lst);
        errors++;
      end
      if (cnt !== o.count) begin
        $error("count mismatch: expected %0d, actual %0d", o.count, cnt);
        errors++;
      end
    endfunction
  endclass

  // dut ports; the inputs are known from time zero
  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic [REQ_W-1:0]         req_type = '0;
  logic signed [DATA_W-1:0] value    = '0;
  logic                     busy;
  logic                     done;
  logic [STAT_W-1:0]        status;
  logic                     has_data;
  logic signed [DATA_W-1:0] data;
  logic                     last;
  logic [CNT_W-1:0]         count;

  dq_shadow shadow = new();
  int       sent    = 0;        // request beats accepted so far
  bit       gaps_on = 1'b1;     // sender gaps allowed
  int       cycles  = 0;

  deque_with_remove_max #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .value    (value),
    .done     (done),
    .status   (status),
    .has_data (has_data),
    .data     (data),
    .last     (last),
    .count    (count)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or missing result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("deque_with_remove_max regression: fail");
      $finish;
    end
  end

  // result monitor: the receiver never stalls, so every strobe is a beat
  always @(posedge clk) begin
    if (!rst && done) shadow.check_result(status, has_data, data, last, count);
  end

  // present one request beat at the falling edge and hold it until taken;
  // start stays high if the next beat follows directly
  task automatic send_beat(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] word);
    @(negedge clk);
    start    <= 1'b1;
    req_type <= req;
    value    <= word;
    do @(posedge clk); while (busy);
    shadow.note_request(req, word);
    sent++;
  endtask

  // sender idle with junk on the payload, which must be ignored
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start    <= 1'b0;
      req_type <= REQ_W'($urandom);
      value    <= $urandom;
    end
  endtask

  // random gap burst, roughly one beat in four, none in the calm stretch
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 7));
  endtask

  // words: extremes and a tiny range for ties, otherwise full 32-bit noise
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2, 3:    return DATA_W'($urandom_range(0, 3)) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_push();
    return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
  endfunction

  function automatic logic [REQ_W-1:0] pick_read();
    return $urandom_range(0, 1) ? REQ_READ_FRONT : REQ_READ_BACK;
  endfunction

  // mixed traffic, with a trickle of undefined codes as noise
  function automatic logic [REQ_W-1:0] pick_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return pick_push();
    if (r < 68) return REQ_REMOVE;
    if (r < 86) return pick_read();
    if (r < 90) return REQ_CLEAR;
    if (r < 94) return $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
    return pick_push();
  endfunction

  task automatic send_gapped(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] word);
    send_beat(req, word);
    maybe_gap();
  endtask

  initial begin : stimulus
    segment_t seg;
    int       len;

    // hold reset, then release it at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty-queue cases and undefined codes
    send_gapped(REQ_READ_FRONT, 0);
    send_gapped(REQ_READ_BACK, 0);
    send_gapped(REQ_REMOVE, 0);
    send_gapped(REQ_CLEAR, 0);
    send_gapped(REQ_SPARE_LO, $urandom);
    send_gapped(REQ_SPARE_HI, $urandom);
    // extremes at both ends, with two equal maxima
    send_gapped(REQ_PUSH_BACK, 5);
    send_gapped(REQ_PUSH_FRONT, WORD_MAX);
    send_gapped(REQ_PUSH_BACK, WORD_MIN);
    send_gapped(REQ_PUSH_FRONT, -1);
    send_gapped(REQ_PUSH_BACK, WORD_MAX);
    send_gapped(REQ_PUSH_BACK, 0);
    send_gapped(REQ_READ_FRONT, 0);
    send_gapped(REQ_READ_BACK, 0);
    // tie: frontmost maximum goes first, then the other one
    send_gapped(REQ_REMOVE, 0);
    send_gapped(REQ_READ_FRONT, 0);
    send_gapped(REQ_REMOVE, 0);
    send_gapped(REQ_REMOVE, 0);
    // undefined code with entries held leaves them alone
    send_gapped(REQ_SPARE_HI, $urandom);
    send_gapped(REQ_READ_BACK, 0);
    send_gapped(REQ_CLEAR, 0);
    send_gapped(REQ_READ_FRONT, 0);
    // single most negative entry still gets removed
    send_gapped(REQ_PUSH_BACK, WORD_MIN);
    send_gapped(REQ_REMOVE, 0);
    send_gapped(REQ_READ_BACK, 0);

    // random: fill runs hit full, drain runs hit empty, mixed in between
    while (sent < ITEMS) begin
      seg = segment_t'($urandom_range(0, 2));
      case (seg)
        SEG_FILL: begin
          while (shadow.held.size() < DEPTH) begin
            if ($urandom_range(0, 9) == 0) send_gapped(pick_read(), 0);
            else send_gapped(pick_push(), pick_word());
          end
          // pushes into a full deque are rejected
          repeat ($urandom_range(1, 2)) send_gapped(pick_push(), pick_word());
          send_gapped(pick_read(), 0);
        end
        SEG_DRAIN: begin
          while (shadow.held.size() > 0) begin
            if ($urandom_range(0, 4) == 0) send_gapped(pick_read(), 0);
            else send_gapped(REQ_REMOVE, 0);
          end
          send_gapped(REQ_REMOVE, 0);
        end
        default: begin
          len = $urandom_range(10, 25);
          repeat (len) send_gapped(pick_mixed(), pick_word());
        end
      endcase
      if (sent >= ITEMS - CALM_ITEMS) gaps_on = 1'b0;
    end

    @(negedge clk);
    start <= 1'b0;

    // drain owed results, then give stray beats time to show up
    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (shadow.errors == 0 && shadow.owed.size() == 0) begin
      $display("deque_with_remove_max regression: pass");
    end else begin
      $display("deque_with_remove_max regression: fail");
    end
    $finish;
  end

endmodule
